### src/sync_length_crc_deframer_top_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_LENGTH_CRC_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CRC_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");

`endif

### src/slcd_pkg.sv
package slcd_pkg;

    localparam int FRAME_LIMIT_DEFAULT = 4096;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'h38;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'hA6;
    localparam logic [7:0]  SYNC_THIRD_RST  = 8'h05;
    localparam logic [12:0] MAX_FRAME_RST   = 13'd4096;
    localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    // Frame positions with a role of their own.
    localparam int POS_HUNT    = 0;
    localparam int POS_SYNC2   = 1;
    localparam int POS_SYNC3   = 2;
    localparam int POS_CMD     = 3;
    localparam int POS_PORT    = 4;
    localparam int POS_IP0     = 5;
    localparam int POS_IP1     = 6;
    localparam int POS_IP2     = 7;
    localparam int POS_IP3     = 8;
    localparam int POS_IPP_HI  = 9;
    localparam int POS_IPP_LO  = 10;
    localparam int POS_PREFIX  = 11;
    localparam int POS_DEVICE  = 12;
    localparam int POS_SEQ     = 13;
    localparam int POS_LEN_HI  = 14;
    localparam int POS_LEN_LO  = 15;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYNC_FIRST  = 3'd0,
        CFG_SYNC_SECOND = 3'd1,
        CFG_SYNC_THIRD  = 3'd2,
        CFG_MAX_FRAME   = 3'd3,
        CFG_CRC_INIT    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_GOOD      = 3'd1,
        KIND_CRC_ERR   = 3'd2,
        KIND_ZERO_LEN  = 3'd3,
        KIND_OVERFLOW  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  port;
        logic [31:0] ipv4;
        logic [15:0] ip_port;
        logic [7:0]  prefix;
        logic [7:0]  device;
        logic [7:0]  seq;
        logic [15:0] length;
    } hdr_t;

    // CRC-16 CCITT, MSB first, one byte per call.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### src/sync_length_crc_deframer_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    rx_byte
// result    out        out_valid / out_ready  result_kind, data_byte, header fields
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle; its whole step (overflow check, sync or header
// capture, byte-wide CRC update, CRC compare) is one level of logic into the
// state and result registers, so the block sustains one item per clock.
// Reset (rst_n, asynchronous) loads the register defaults and starts the hunt.
// The result register is the only stall point: a new byte is taken whenever it
// is empty or its item is being taken in the same cycle.
module sync_length_crc_deframer_top #(
    parameter int FRAME_LIMIT = slcd_pkg::FRAME_LIMIT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       result_kind,
    output logic [7:0]                       data_byte,
    output logic [7:0]                       command_byte,
    output logic [7:0]                       port_number,
    output logic [31:0]                      ipv4_address,
    output logic [15:0]                      ip_port,
    output logic [7:0]                       device_prefix,
    output logic [7:0]                       device_id,
    output logic [7:0]                       sequence_number,
    output logic [15:0]                      payload_length,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(FRAME_LIMIT + 1);
    localparam int LIM_W = (POS_W > 13) ? POS_W : 13;

    // Configuration registers
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  sync_third_reg;
    logic [12:0] max_frame_reg;
    logic [15:0] crc_init_reg;

    // Frame state
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [16:0]      left_reg,     left_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [7:0]       crc_hi_reg,   crc_hi_next;
    slcd_pkg::hdr_t   hdr_reg,      hdr_next;

    // Result register
    logic            out_valid_reg, out_valid_next;
    slcd_pkg::kind_t kind_reg,      kind_next;
    logic [7:0]      data_reg,      data_next;
    slcd_pkg::hdr_t  out_hdr_reg,   out_hdr_next;

    logic             in_accept;
    logic [LIM_W-1:0] limit;
    logic             overflow;
    logic             emit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign data_byte       = data_reg;
    assign command_byte    = out_hdr_reg.cmd;
    assign port_number     = out_hdr_reg.port;
    assign ipv4_address    = out_hdr_reg.ipv4;
    assign ip_port         = out_hdr_reg.ip_port;
    assign device_prefix   = out_hdr_reg.prefix;
    assign device_id       = out_hdr_reg.device;
    assign sequence_number = out_hdr_reg.seq;
    assign payload_length  = out_hdr_reg.length;

    always_comb
    begin
        if (LIM_W'(max_frame_reg) > LIM_W'(FRAME_LIMIT))
        begin
            limit = LIM_W'(FRAME_LIMIT);
        end
        else
        begin
            limit = LIM_W'(max_frame_reg);
        end
        overflow = (pos_reg != '0) && (LIM_W'(pos_reg) >= limit);
    end

    // One byte step: overflow restart first, then the position's own work.
    always_comb
    begin
        pos_next     = pos_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        crc_hi_next  = crc_hi_reg;
        hdr_next     = hdr_reg;
        emit         = 1'b0;
        kind_next    = slcd_pkg::KIND_OVERFLOW;
        data_next    = 8'h00;
        out_hdr_next = hdr_reg;

        if (overflow)
        begin
            emit        = 1'b1;
            pos_next    = '0;
            left_next   = '0;
            crc_next    = crc_init_reg;
            crc_hi_next = 8'h00;
            hdr_next    = '0;
        end

        case (pos_next)
            POS_W'(slcd_pkg::POS_HUNT):
            begin
                if (rx_byte == sync_first_reg)
                begin
                    crc_next = slcd_pkg::crc16_byte(crc_init_reg, rx_byte);
                    pos_next = POS_W'(slcd_pkg::POS_SYNC2);
                end
            end
            POS_W'(slcd_pkg::POS_SYNC2),
            POS_W'(slcd_pkg::POS_SYNC3):
            begin
                if (rx_byte == ((pos_next == POS_W'(slcd_pkg::POS_SYNC2)) ?
                                sync_second_reg : sync_third_reg))
                begin
                    crc_next = slcd_pkg::crc16_byte(crc_reg, rx_byte);
                    pos_next = pos_next + POS_W'(1);
                end
                else
                begin
                    pos_next    = '0;
                    left_next   = '0;
                    crc_next    = crc_init_reg;
                    crc_hi_next = 8'h00;
                    hdr_next    = '0;
                end
            end
            POS_W'(slcd_pkg::POS_LEN_HI):
            begin
                crc_next            = slcd_pkg::crc16_byte(crc_reg, rx_byte);
                hdr_next.length     = {rx_byte, 8'h00};
                pos_next            = POS_W'(slcd_pkg::POS_LEN_LO);
            end
            POS_W'(slcd_pkg::POS_LEN_LO):
            begin
                crc_next              = slcd_pkg::crc16_byte(crc_reg, rx_byte);
                hdr_next.length[7:0]  = rx_byte;
                if (hdr_next.length == 16'h0000)
                begin
                    emit         = 1'b1;
                    kind_next    = slcd_pkg::KIND_ZERO_LEN;
                    out_hdr_next = hdr_next;
                    pos_next     = '0;
                    left_next    = '0;
                    crc_next     = crc_init_reg;
                    crc_hi_next  = 8'h00;
                    hdr_next     = '0;
                end
                else
                begin
                    left_next = {1'b0, hdr_next.length} + 17'd2;
                    pos_next  = pos_next + POS_W'(1);
                end
            end
            default:
            begin
                if (pos_next < POS_W'(slcd_pkg::POS_LEN_HI))
                begin
                    crc_next = slcd_pkg::crc16_byte(crc_reg, rx_byte);
                    pos_next = pos_next + POS_W'(1);
                    case (pos_reg)
                        POS_W'(slcd_pkg::POS_CMD):    hdr_next.cmd            = rx_byte;
                        POS_W'(slcd_pkg::POS_PORT):   hdr_next.port           = rx_byte;
                        POS_W'(slcd_pkg::POS_IP0):    hdr_next.ipv4[31:24]    = rx_byte;
                        POS_W'(slcd_pkg::POS_IP1):    hdr_next.ipv4[23:16]    = rx_byte;
                        POS_W'(slcd_pkg::POS_IP2):    hdr_next.ipv4[15:8]     = rx_byte;
                        POS_W'(slcd_pkg::POS_IP3):    hdr_next.ipv4[7:0]      = rx_byte;
                        POS_W'(slcd_pkg::POS_IPP_HI): hdr_next.ip_port[15:8]  = rx_byte;
                        POS_W'(slcd_pkg::POS_IPP_LO): hdr_next.ip_port[7:0]   = rx_byte;
                        POS_W'(slcd_pkg::POS_PREFIX): hdr_next.prefix         = rx_byte;
                        POS_W'(slcd_pkg::POS_DEVICE): hdr_next.device         = rx_byte;
                        POS_W'(slcd_pkg::POS_SEQ):    hdr_next.seq            = rx_byte;
                        default:                      hdr_next.cmd            = hdr_reg.cmd;
                    endcase
                end
                else if (left_reg > 17'd2)
                begin
                    emit      = 1'b1;
                    kind_next = slcd_pkg::KIND_DATA;
                    data_next = rx_byte;
                    crc_next  = slcd_pkg::crc16_byte(crc_reg, rx_byte);
                    left_next = left_reg - 17'd1;
                    pos_next  = pos_next + POS_W'(1);
                end
                else if (left_reg == 17'd2)
                begin
                    crc_hi_next = rx_byte;
                    left_next   = 17'd1;
                    pos_next    = pos_next + POS_W'(1);
                end
                else
                begin
                    // Last CRC byte closes the frame.
                    emit = 1'b1;
                    if ((crc_hi_reg == crc_reg[15:8]) && (rx_byte == crc_reg[7:0]))
                    begin
                        kind_next = slcd_pkg::KIND_GOOD;
                    end
                    else
                    begin
                        kind_next = slcd_pkg::KIND_CRC_ERR;
                    end
                    pos_next    = '0;
                    left_next   = '0;
                    crc_next    = crc_init_reg;
                    crc_hi_next = 8'h00;
                    hdr_next    = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slcd_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slcd_pkg::SYNC_SECOND_RST;
            sync_third_reg  <= slcd_pkg::SYNC_THIRD_RST;
            max_frame_reg   <= slcd_pkg::MAX_FRAME_RST;
            crc_init_reg    <= slcd_pkg::CRC_INIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slcd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                slcd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                slcd_pkg::CFG_SYNC_THIRD:  sync_third_reg  <= cfg_data[7:0];
                slcd_pkg::CFG_MAX_FRAME:   max_frame_reg   <= cfg_data[12:0];
                slcd_pkg::CFG_CRC_INIT:    crc_init_reg    <= cfg_data[15:0];
                default:                   crc_init_reg    <= crc_init_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            left_reg   <= '0;
            crc_reg    <= slcd_pkg::CRC_INIT_RST;
            crc_hi_reg <= 8'h00;
            hdr_reg    <= '0;
        end
        else if (in_accept)
        begin
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
            hdr_reg    <= hdr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            kind_reg    <= kind_next;
            data_reg    <= data_next;
            out_hdr_reg <= out_hdr_next;
        end
    end

`include "sync_length_crc_deframer_top_assert.svh"

    `SLCD_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, LIM_W'(pos_reg) <= LIM_W'(FRAME_LIMIT))
    `SLCD_ASSERT_IMPL(a_left_in_payload, clk, rst_n, left_reg != 17'd0,
                      pos_reg >= POS_W'(slcd_pkg::POS_LEN_LO + 1))
    `SLCD_ASSERT_NEXT(a_ctrl_zero_data, clk, rst_n, in_accept && emit &&
                      (kind_next != slcd_pkg::KIND_DATA), data_byte == 8'h00)

endmodule
